@@ rtl/smd_pkg.sv @@
// Package for the SHA-1 message digest unit: state codes, control structs,
// initial hash words, round constants and rotate helpers.
// No dependencies.
`timescale 1ns / 1ps

package smd_pkg;

    typedef logic [4:0][31:0] words5_t;

    localparam words5_t H_INIT = '{
        4: 32'hC3D2E1F0,
        3: 32'h10325476,
        2: 32'h98BADCFE,
        1: 32'hEFCDAB89,
        0: 32'h67452301
    };

    localparam logic [31:0] K_00_19 = 32'h5A827999;
    localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
    localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
    localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [6:0] LAST_T    = 7'd79;
    localparam logic [6:0] SCHED_T   = 7'd16;
    localparam logic [2:0] LAST_IDX  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_RND,
        ST_FIN,
        ST_PAD80,
        ST_PADZ,
        ST_PADLEN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        load;
        logic        round;
        logic        fin;
        logic        clear;
        logic [6:0]  t;
    } cmp_ctl_t;

    typedef struct packed {
        logic        we;
        logic [3:0]  waddr;
        logic [31:0] wdata;
        logic [3:0]  raddr0;
        logic [3:0]  raddr1;
    } ram_req_t;

    function automatic logic [31:0] rotl1(input logic [31:0] v);
        return {v[30:0], v[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] v);
        return {v[26:0], v[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] v);
        return {v[1:0], v[31:2]};
    endfunction

endpackage

@@ rtl/smd_in_if.sv @@
// Input channel of the SHA-1 message digest unit: one message byte a word.
// No dependencies.
`timescale 1ns / 1ps

interface smd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input end_of_message, output ready);
endinterface

@@ rtl/smd_out_if.sv @@
// Output channel of the SHA-1 message digest unit: one digest word a word.
// No dependencies.
`timescale 1ns / 1ps

interface smd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

@@ rtl/sha1_message_digest_unit.sv @@
// SHA-1 message digest unit: byte packer, block sequencer and digest output.
// Depends on smd_pkg, smd_in_if, smd_out_if, smd_window_ram, smd_compress.
//
// Takes one byte per cycle while a block fills. The byte that completes a
// 64-byte block holds the input off while the block is compressed: the
// 16-word window sits in a two-read-port RAM, so rounds 0-15 read their
// word in ST_RD1 and rounds 16-79 read the four schedule taps in ST_RD1
// and ST_RD2, each before ST_RND runs the round; ST_FIN then folds the
// working variables into the chain. An end-of-message word then leads
// through each padding and length byte in turn, with a pause on reaching
// the length field, plus one or two block compressions, before the five
// digest words appear, H0 first, one per cycle as the sink takes them. The
// next message starts from the initial hash after the last word is taken.
`timescale 1ns / 1ps

module sha1_message_digest_unit
(
    input  logic     clk,
    input  logic     rst_n,
    smd_in_if.sink   data_in,
    smd_out_if.source digest_out
);

    smd_pkg::state_t   state_reg;
    smd_pkg::state_t   state_next;
    smd_pkg::state_t   ret_reg;
    smd_pkg::state_t   ret_next;
    logic [6:0]        t_reg;
    logic [6:0]        t_next;
    logic [5:0]        pos_reg;
    logic [5:0]        pos_next;
    logic [63:0]       bit_length_reg;
    logic [63:0]       bit_length_next;
    logic [2:0]        idx_reg;
    logic [2:0]        idx_next;
    logic [31:0]       acc_reg;
    logic [31:0]       acc_next;
    logic [31:0]       x_reg;

    logic              in_acc;
    logic              out_acc;
    logic              put_en;
    logic [7:0]        put_data;
    logic              full;
    logic [7:0]        len_byte;
    logic [4:0]        byte_sh;
    logic [5:0]        len_sh;
    logic              sched;
    logic [31:0]       rd_data0;
    logic [31:0]       rd_data1;
    logic [31:0]       w;
    smd_pkg::ram_req_t req;
    smd_pkg::cmp_ctl_t ctl;
    smd_pkg::words5_t  chain;

    assign in_acc   = data_in.valid && data_in.ready;
    assign out_acc  = digest_out.valid && digest_out.ready;
    assign full     = (pos_reg == smd_pkg::LAST_POS);
    assign sched    = (t_reg >= smd_pkg::SCHED_T);
    assign len_sh   = {~pos_reg[2:0], 3'b000};
    assign len_byte = 8'(bit_length_reg >> len_sh);
    assign byte_sh  = {~pos_reg[1:0], 3'b000};
    assign w        = sched ? smd_pkg::rotl1(x_reg ^ rd_data0 ^ rd_data1) : rd_data0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            smd_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (data_in.has_byte && full)
                    begin
                        state_next = smd_pkg::ST_RD1;
                        ret_next   = data_in.end_of_message ? smd_pkg::ST_PAD80
                                                            : smd_pkg::ST_IDLE;
                    end
                    else if (data_in.end_of_message)
                    begin
                        state_next = smd_pkg::ST_PAD80;
                    end
                end
            end
            smd_pkg::ST_RD1:
            begin
                state_next = sched ? smd_pkg::ST_RD2 : smd_pkg::ST_RND;
            end
            smd_pkg::ST_RD2:
            begin
                state_next = smd_pkg::ST_RND;
            end
            smd_pkg::ST_RND:
            begin
                state_next = (t_reg == smd_pkg::LAST_T) ? smd_pkg::ST_FIN
                                                        : smd_pkg::ST_RD1;
            end
            smd_pkg::ST_FIN:
            begin
                state_next = ret_reg;
            end
            smd_pkg::ST_PAD80:
            begin
                state_next = full ? smd_pkg::ST_RD1 : smd_pkg::ST_PADZ;
                ret_next   = smd_pkg::ST_PADZ;
            end
            smd_pkg::ST_PADZ:
            begin
                if (pos_reg == smd_pkg::LEN_POS)
                begin
                    state_next = smd_pkg::ST_PADLEN;
                end
                else if (full)
                begin
                    state_next = smd_pkg::ST_RD1;
                    ret_next   = smd_pkg::ST_PADZ;
                end
            end
            smd_pkg::ST_PADLEN:
            begin
                if (full)
                begin
                    state_next = smd_pkg::ST_RD1;
                    ret_next   = smd_pkg::ST_OUT;
                end
            end
            smd_pkg::ST_OUT:
            begin
                if (out_acc && idx_reg == smd_pkg::LAST_IDX)
                begin
                    state_next = smd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = smd_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        data_in.ready    = 1'b0;
        digest_out.valid = 1'b0;
        put_en           = 1'b0;
        put_data         = data_in.data_byte;
        ctl              = '0;
        ctl.t            = t_reg;
        req.raddr0       = t_reg[3:0];
        req.raddr1       = t_reg[3:0] - 4'd3;
        unique case (state_reg)
            smd_pkg::ST_IDLE:
            begin
                data_in.ready = 1'b1;
                put_en        = data_in.valid && data_in.has_byte;
            end
            smd_pkg::ST_RD1:
            begin
            end
            smd_pkg::ST_RD2:
            begin
                req.raddr0 = t_reg[3:0] - 4'd8;
                req.raddr1 = t_reg[3:0] - 4'd14;
            end
            smd_pkg::ST_RND:
            begin
                ctl.round = 1'b1;
            end
            smd_pkg::ST_FIN:
            begin
                ctl.fin = 1'b1;
            end
            smd_pkg::ST_PAD80:
            begin
                put_en   = 1'b1;
                put_data = smd_pkg::PAD_BYTE;
            end
            smd_pkg::ST_PADZ:
            begin
                put_en   = (pos_reg != smd_pkg::LEN_POS);
                put_data = 8'h00;
            end
            smd_pkg::ST_PADLEN:
            begin
                put_en   = 1'b1;
                put_data = len_byte;
            end
            smd_pkg::ST_OUT:
            begin
                digest_out.valid = 1'b1;
                ctl.clear        = digest_out.ready && (idx_reg == smd_pkg::LAST_IDX);
            end
            default:
            begin
            end
        endcase
        ctl.load = put_en && full;

        acc_next = ((pos_reg[1:0] == 2'd0) ? 32'h0 : acc_reg)
                 | (32'(put_data) << byte_sh);

        req.we    = 1'b0;
        req.waddr = pos_reg[5:2];
        req.wdata = acc_next;
        if (put_en && pos_reg[1:0] == 2'd3)
        begin
            req.we = 1'b1;
        end
        else if (state_reg == smd_pkg::ST_RND && sched)
        begin
            req.we    = 1'b1;
            req.waddr = t_reg[3:0];
            req.wdata = w;
        end
    end

    // counters
    always_comb
    begin
        pos_next        = pos_reg;
        t_next          = t_reg;
        bit_length_next = bit_length_reg;
        idx_next        = idx_reg;
        if (put_en)
        begin
            pos_next = pos_reg + 6'd1;
        end
        if (ctl.load)
        begin
            t_next = 7'd0;
        end
        else if (ctl.round)
        begin
            t_next = t_reg + 7'd1;
        end
        if (state_reg == smd_pkg::ST_IDLE && in_acc && data_in.has_byte)
        begin
            bit_length_next = bit_length_reg + 64'd8;
        end
        if (out_acc)
        begin
            idx_next = idx_reg + 3'd1;
        end
        if (ctl.clear)
        begin
            pos_next        = 6'd0;
            bit_length_next = 64'd0;
            idx_next        = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= smd_pkg::ST_IDLE;
            ret_reg        <= smd_pkg::ST_IDLE;
            t_reg          <= 7'd0;
            pos_reg        <= 6'd0;
            bit_length_reg <= 64'd0;
            idx_reg        <= 3'd0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            t_reg          <= t_next;
            pos_reg        <= pos_next;
            bit_length_reg <= bit_length_next;
            idx_reg        <= idx_next;
        end
    end

    // hold the partial word and the first schedule pair
    always_ff @(posedge clk)
    begin
        if (put_en)
        begin
            acc_reg <= acc_next;
        end
        if (state_reg == smd_pkg::ST_RD2)
        begin
            x_reg <= rd_data0 ^ rd_data1;
        end
    end

    smd_window_ram u_ram
    (
        .clk      (clk),
        .req      (req),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1)
    );

    smd_compress u_compress
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .w     (w),
        .chain (chain)
    );

    assign digest_out.digest_word = chain[idx_reg];
    assign digest_out.word_index  = idx_reg;
    assign digest_out.last_word   = (idx_reg == smd_pkg::LAST_IDX);

endmodule

@@ rtl/smd_window_ram.sv @@
// Message window memory: 16 x 32, one write port, two registered read ports.
// Depends on smd_pkg.
`timescale 1ns / 1ps

module smd_window_ram
(
    input  logic              clk,
    input  smd_pkg::ram_req_t req,
    output logic [31:0]       rd_data0,
    output logic [31:0]       rd_data1
);

    logic [31:0] mem [16];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data0 <= mem[req.raddr0];
        rd_data1 <= mem[req.raddr1];
    end

endmodule

@@ rtl/smd_compress.sv @@
// SHA-1 round datapath: working variables, chain value and the round function.
// Depends on smd_pkg.
`timescale 1ns / 1ps

module smd_compress
(
    input  logic              clk,
    input  logic              rst_n,
    input  smd_pkg::cmp_ctl_t ctl,
    input  logic [31:0]       w,
    output smd_pkg::words5_t  chain
);

    smd_pkg::words5_t wv_reg;
    smd_pkg::words5_t wv_next;
    smd_pkg::words5_t chain_reg;
    smd_pkg::words5_t chain_next;
    logic [31:0]      f;
    logic [31:0]      k;
    logic [31:0]      tmp;

    always_comb
    begin
        if (ctl.t < 7'd20)
        begin
            f = (wv_reg[1] & wv_reg[2]) | (~wv_reg[1] & wv_reg[3]);
            k = smd_pkg::K_00_19;
        end
        else if (ctl.t < 7'd40)
        begin
            f = wv_reg[1] ^ wv_reg[2] ^ wv_reg[3];
            k = smd_pkg::K_20_39;
        end
        else if (ctl.t < 7'd60)
        begin
            f = (wv_reg[1] & wv_reg[2]) | (wv_reg[1] & wv_reg[3])
              | (wv_reg[2] & wv_reg[3]);
            k = smd_pkg::K_40_59;
        end
        else
        begin
            f = wv_reg[1] ^ wv_reg[2] ^ wv_reg[3];
            k = smd_pkg::K_60_79;
        end
        tmp = smd_pkg::rotl5(wv_reg[0]) + f + wv_reg[4] + k + w;
    end

    always_comb
    begin
        wv_next    = wv_reg;
        chain_next = chain_reg;
        if (ctl.load)
        begin
            wv_next = chain_reg;
        end
        else if (ctl.round)
        begin
            wv_next[4] = wv_reg[3];
            wv_next[3] = wv_reg[2];
            wv_next[2] = smd_pkg::rotl30(wv_reg[1]);
            wv_next[1] = wv_reg[0];
            wv_next[0] = tmp;
        end
        if (ctl.clear)
        begin
            chain_next = smd_pkg::H_INIT;
        end
        else if (ctl.fin)
        begin
            for (int i = 0; i < 5; i++)
            begin
                chain_next[i] = chain_reg[i] + wv_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wv_reg <= wv_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= smd_pkg::H_INIT;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    assign chain = chain_reg;

endmodule

@@ rtl/smd_checker.sv @@
// Port-level checks for the SHA-1 message digest unit, with its bind.
// Depends on smd_pkg and sha1_message_digest_unit.
`timescale 1ns / 1ps

module smd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> word_index <= smd_pkg::LAST_IDX)
        else $error("digest word index out of range");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == smd_pkg::LAST_IDX)))
        else $error("last word flag does not match index");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while digest is pending");

    a_end_of_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_word) |=> !out_valid)
        else $error("digest output continues after last word");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(digest_word) && $stable(word_index)))
        else $error("stalled digest word changed");

endmodule

bind sha1_message_digest_unit smd_checker u_smd_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (data_in.ready),
    .out_valid   (digest_out.valid),
    .out_ready   (digest_out.ready),
    .digest_word (digest_out.digest_word),
    .word_index  (digest_out.word_index),
    .last_word   (digest_out.last_word)
);

@@ bench/sha1_message_digest_unit_tb.sv @@
// Testbench for sha1_message_digest_unit: drives message bytes and checks the digest words.
// A SHA-1 predictor built into the bench supplies the expected words.
// Depends on smd_in_if, smd_out_if and sha1_message_digest_unit.
`timescale 1ns / 1ps

module sha1_message_digest_unit_tb;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          SETTLE_CYCLES = 600;
    localparam logic [2:0]  FINAL_INDEX = 3'd4;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [5:0]  LENGTH_SLOT = 6'd56;
    localparam logic [31:0] ROUND_K0 = 32'h5A827999;
    localparam logic [31:0] ROUND_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] ROUND_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] ROUND_K3 = 32'hCA62C1D6;
    localparam logic [31:0] SEED_H [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_entry_t;

    logic clk = 1'b0;
    logic rst_n;

    smd_in_if  data_if ();
    smd_out_if digest_if ();

    sha1_message_digest_unit u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_in    (data_if),
        .digest_out (digest_if)
    );

    always #4 clk = ~clk;

    logic [31:0]   hash_h [5];
    logic [31:0]   block_w [16];
    logic [63:0]   message_bits;
    logic [5:0]    fill_pos;
    digest_entry_t expected_digest [$];

    int   fail_count = 0;
    int   cycle_count = 0;
    int   rx_stall_left = 0;
    logic quiet_tx = 1'b0;
    logic quiet_rx = 1'b0;
    logic tx_driving = 1'b0;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 5; i++)
        begin
            hash_h[i] = SEED_H[i];
        end
        message_bits = '0;
        fill_pos = '0;
    endfunction

    function automatic void fold_block();
        logic [31:0] a, b, c, d, e, f, k, w, sum;
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (int t = 0; t < 80; t++)
        begin
            if (t >= 16)
            begin
                w = block_w[(t - 3) & 15] ^ block_w[(t - 8) & 15]
                  ^ block_w[(t - 14) & 15] ^ block_w[t & 15];
                block_w[t & 15] = rol32(w, 1);
            end
            w = block_w[t & 15];
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = ROUND_K0;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = ROUND_K1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = ROUND_K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = ROUND_K3;
            end
            sum = rol32(a, 5) + f + e + k + w;
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = sum;
        end
        hash_h[0] += a;
        hash_h[1] += b;
        hash_h[2] += c;
        hash_h[3] += d;
        hash_h[4] += e;
    endfunction

    function automatic void absorb_byte(input logic [7:0] value);
        logic [3:0] slot;
        slot = fill_pos[5:2];
        if (fill_pos[1:0] == 2'd0)
        begin
            block_w[slot] = '0;
        end
        block_w[slot] = block_w[slot] | ({24'd0, value} << (8 * (3 - fill_pos[1:0])));
        if (fill_pos == 6'd63)
        begin
            fold_block();
        end
        fill_pos = fill_pos + 6'd1;
    endfunction

    function automatic void predict_digest(input logic [7:0] data_val, input logic has_val,
                                           input logic eom_val);
        logic [63:0]   length_bits;
        digest_entry_t entry;
        if (has_val)
        begin
            absorb_byte(data_val);
            message_bits += 64'd8;
        end
        if (eom_val)
        begin
            length_bits = message_bits;
            absorb_byte(PAD_MARK);
            while (fill_pos != LENGTH_SLOT)
            begin
                absorb_byte(8'h00);
            end
            for (int i = 0; i < 8; i++)
            begin
                absorb_byte(length_bits[63 - 8 * i -: 8]);
            end
            for (int i = 0; i < 5; i++)
            begin
                entry.word = hash_h[i];
                entry.index = 3'(i);
                entry.last = (3'(i) == FINAL_INDEX);
                expected_digest = {expected_digest, entry};
            end
            restart_hash();
        end
    endfunction

    function automatic int gap_length();
        if ($urandom_range(0, 99) < 85)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // Receive side: check accepted words, then pick ready for the next cycle
    task automatic check_digest_word();
        digest_entry_t exp_w;
        if (expected_digest.size() == 0)
        begin
            $display("%0t: unexpected digest word %h index %0d last %b", $time,
                     digest_if.digest_word, digest_if.word_index, digest_if.last_word);
            fail_count++;
        end
        else
        begin
            exp_w = expected_digest.pop_front();
            if (digest_if.digest_word !== exp_w.word)
            begin
                $display("%0t: digest_word expected %h, actual %h", $time,
                         exp_w.word, digest_if.digest_word);
                fail_count++;
            end
            if (digest_if.word_index !== exp_w.index)
            begin
                $display("%0t: word_index expected %0d, actual %0d", $time,
                         exp_w.index, digest_if.word_index);
                fail_count++;
            end
            if (digest_if.last_word !== exp_w.last)
            begin
                $display("%0t: last_word expected %b, actual %b", $time,
                         exp_w.last, digest_if.last_word);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && digest_if.valid === 1'b1 && digest_if.ready === 1'b1)
        begin
            check_digest_word();
        end
        if (rx_stall_left > 0)
        begin
            digest_if.ready <= 1'b0;
            rx_stall_left--;
        end
        else
        begin
            digest_if.ready <= 1'b1;
            if (!quiet_rx && $urandom_range(0, 99) < 25)
            begin
                rx_stall_left = gap_length();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d digest words outstanding",
                     cycle_count, expected_digest.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic [7:0] data_val, input logic has_val,
                             input logic eom_val);
        int gap;
        gap = (quiet_tx || $urandom_range(0, 99) < 55) ? 0 : gap_length();
        if (gap > 0)
        begin
            if (tx_driving)
            begin
                data_if.valid <= 1'b0;
                tx_driving = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        data_if.valid <= 1'b1;
        data_if.data_byte <= data_val;
        data_if.has_byte <= has_val;
        data_if.end_of_message <= eom_val;
        tx_driving = 1'b1;
        @(posedge clk);
        while (data_if.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        predict_digest(data_val, has_val, eom_val);
    endtask

    // Hold the input idle until every predicted word has been taken
    task automatic wait_drain();
        if (tx_driving)
        begin
            data_if.valid <= 1'b0;
            tx_driving = 1'b0;
        end
        do
        begin
            @(posedge clk);
        end
        while (expected_digest.size() != 0);
    endtask

    task automatic send_message(input int len, input logic noisy);
        logic end_on_byte;
        end_on_byte = (len > 0) && $urandom_range(0, 1);
        for (int i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(0, 99) < 8)
            begin
                send_word(8'($urandom), 1'b0, 1'b0);
            end
            send_word(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte)
        begin
            send_word(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic test_idle_and_empty();
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hA5, 1'b0, 1'b1);
    endtask

    task automatic test_byte_with_end();
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
    endtask

    task automatic test_end_without_byte();
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h5A, 1'b0, 1'b0);
        send_word(8'h63, 1'b1, 1'b0);
        send_word(8'hC3, 1'b0, 1'b1);
    endtask

    task automatic test_end_on_byte();
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        wait_drain();
    endtask

    // Random lengths 0-8, plus 56 (length spills to a second block) and 64 (fills a block)
    task automatic test_random_messages();
        int lengths[$];
        int j, held;
        lengths = '{56, 64};
        repeat (4) lengths = {lengths, int'($urandom_range(0, 8))};
        for (int i = lengths.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            held = lengths[i];
            lengths[i] = lengths[j];
            lengths[j] = held;
        end
        foreach (lengths[m])
        begin
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            send_message(lengths[m], 1'b1);
            if ($urandom_range(0, 2) == 0)
            begin
                wait_drain();
            end
        end
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        data_if.valid <= 1'b0;
        data_if.data_byte <= '0;
        data_if.has_byte <= 1'b0;
        data_if.end_of_message <= 1'b0;
        restart_hash();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_empty();
        test_byte_with_end();
        test_end_without_byte();
        test_end_on_byte();
        test_random_messages();

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_digest.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
